>>> rtl/gregorian_day_difference_core_defines.svh
// ----------------------------------------------------------------------------
// Day difference core - assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAY_DIFFERENCE_CORE_DEFINES_SVH
`define GREGORIAN_DAY_DIFFERENCE_CORE_DEFINES_SVH

// same-cycle implication
`define GDD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GDD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// Day difference package
// Field widths, status codes, command struct and calendar helper functions.
// ----------------------------------------------------------------------------
package gdd_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int COUNT_W  = 22;
	localparam int STATUS_W = 2;

	localparam int CENT_W   = 8;   // floor(year / 100), year below 16384
	localparam int LEAPS_W  = 12;  // leap years below a year
	localparam int DOY_W    = 9;   // zero-based day of year
	localparam int SPAN_W   = 23;  // 365 * year difference
	localparam int SUM_W    = 24;

	// reciprocal of 100: exact for every dividend below 43690
	localparam int                DIV100_SHIFT = 21;
	localparam int                RECIP_W      = 15;
	localparam logic [RECIP_W-1:0] DIV100_MUL  = 15'd20972;

	localparam logic [YEAR_W-1:0]  CENTURY       = 14'd100;
	localparam logic [DOY_W-1:0]   DAYS_PER_YEAR = 9'd365;
	localparam logic [COUNT_W-1:0] COUNT_MAX     = 22'd4194303;
	localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MONTH = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DAY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ORDER = 2'd3;

	typedef struct packed {
		logic latch;
		logic div_first;
		logic div_second;
		logic leap_en;
		logic check_en;
		logic span_en;
		logic load_out;
	} gdd_cmd_t;

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd2:                   len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] v;
		unique case (m)
			4'd2:    v = 9'd31;
			4'd3:    v = 9'd59;
			4'd4:    v = 9'd90;
			4'd5:    v = 9'd120;
			4'd6:    v = 9'd151;
			4'd7:    v = 9'd181;
			4'd8:    v = 9'd212;
			4'd9:    v = 9'd243;
			4'd10:   v = 9'd273;
			4'd11:   v = 9'd304;
			4'd12:   v = 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// q is floor(y / 100)
	function automatic logic is_leap(input logic [YEAR_W-1:0] y,
		input logic [CENT_W-1:0] q);
		logic [YEAR_W-1:0] hund;
		logic              r0;
		hund = YEAR_W'(q) * CENTURY;
		r0   = (y == hund);
		return r0 ? (q[1:0] == 2'b00) : (y[1:0] == 2'b00);
	endfunction

	// leap years in [0, y): ceil(y/4) - ceil(y/100) + ceil(y/400)
	function automatic logic [LEAPS_W-1:0] leaps_below(input logic [YEAR_W-1:0] y,
		input logic [CENT_W-1:0] q);
		logic [YEAR_W-1:0]  hund;
		logic               r0;
		logic [LEAPS_W:0]   c4;
		logic [LEAPS_W:0]   c100;
		logic [LEAPS_W:0]   c400;
		logic [LEAPS_W:0]   sum;
		hund = YEAR_W'(q) * CENTURY;
		r0   = (y == hund);
		c4   = (LEAPS_W+1)'(y >> 2) + (LEAPS_W+1)'(y[1:0] != 2'b00);
		c100 = (LEAPS_W+1)'(q) + (LEAPS_W+1)'(!r0);
		c400 = (LEAPS_W+1)'(q >> 2) + (LEAPS_W+1)'(!(r0 && (q[1:0] == 2'b00)));
		sum  = c4 - c100 + c400;
		return sum[LEAPS_W-1:0];
	endfunction

endpackage

>>> rtl/gregorian_day_difference_core.sv
// ----------------------------------------------------------------------------
// Gregorian day difference core
// Counts the days between two calendar dates, with range and order checks.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one word: both dates
//   (day, month, 14-bit year) and include_end. A word is taken on a
//   rising edge with req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall) returns day_count and status
//   for every request word, in order.
//   Status: ok, bad month, bad day, or second date before the first; the
//   count is zero whenever status is not ok, and saturates at 4194303.
// Timing:
//   One word is in flight at a time. After acceptance the controller steps
//   through both divides, the leap, check, span and add steps; the result
//   then sits in the output register and the core takes the next word once
//   it is back in idle. The pace is set by the controller's step sequence
//   over the single shared divide-by-100 multiplier and the 365-day multiply.
// Stalls and reset:
//   A held result waits in the output register; the core still finishes
//   the next word's sums but holds it until the register is emptied.
//   Reset empties both channels and returns the controller to idle.
// ----------------------------------------------------------------------------
module gregorian_day_difference_core import gdd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [DAY_W-1:0]    first_day,
	input  logic [MONTH_W-1:0]  first_month,
	input  logic [YEAR_W-1:0]   first_year,
	input  logic [DAY_W-1:0]    second_day,
	input  logic [MONTH_W-1:0]  second_month,
	input  logic [YEAR_W-1:0]   second_year,
	input  logic                include_end,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [COUNT_W-1:0]  day_count,
	output logic [STATUS_W-1:0] status
);

	// command bundle from controller to datapath
	gdd_cmd_t cmd;

	// sequence the steps and own both handshakes
	gdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// operand capture, leap-year arithmetic and the result register
	gdd_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.first_day    (first_day),
		.first_month  (first_month),
		.first_year   (first_year),
		.second_day   (second_day),
		.second_month (second_month),
		.second_year  (second_year),
		.include_end  (include_end),
		.day_count    (day_count),
		.status       (status)
	);

endmodule

>>> rtl/gdd_ctrl.sv
// ----------------------------------------------------------------------------
// Day difference controller
// Steps one word through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
`include "gregorian_day_difference_core_defines.svh"

module gdd_ctrl import gdd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output gdd_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV1  = 3'd1;
	localparam logic [2:0] S_DIV2  = 3'd2;
	localparam logic [2:0] S_LEAP  = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_SPAN  = 3'd5;
	localparam logic [2:0] S_ADD   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_valid_q;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.latch      = (state_q == S_IDLE) && req_valid;
		cmd.div_first  = (state_q == S_DIV1);
		cmd.div_second = (state_q == S_DIV2);
		cmd.leap_en    = (state_q == S_LEAP);
		cmd.check_en   = (state_q == S_CHECK);
		cmd.span_en    = (state_q == S_SPAN);
		// load only when the output register is free or being emptied
		cmd.load_out   = (state_q == S_ADD) && (!rsp_valid_q || !rsp_stall);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (req_valid) begin
				state_d = S_DIV1;
			end
			S_DIV1:  state_d = S_DIV2;
			S_DIV2:  state_d = S_LEAP;
			S_LEAP:  state_d = S_CHECK;
			S_CHECK: state_d = S_SPAN;
			S_SPAN:  state_d = S_ADD;
			S_ADD:   if (cmd.load_out) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`GDD_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, state_q == S_DIV1,
		"accepted word did not start the division step")
	`GDD_ASSERT_NEXT(a_blocked_waits, (state_q == S_ADD) && !cmd.load_out,
		(state_q == S_ADD) && rsp_valid_q, "blocked result left the final step")
	`GDD_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.latch, cmd.div_first, cmd.div_second,
		cmd.leap_en, cmd.check_en, cmd.span_en, cmd.load_out}), "overlapping commands")

endmodule

>>> rtl/gdd_dpath.sv
// ----------------------------------------------------------------------------
// Day difference datapath
// Holds the operands, a shared divide-by-100 unit and the result register.
// ----------------------------------------------------------------------------
`include "gregorian_day_difference_core_defines.svh"

module gdd_dpath import gdd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  gdd_cmd_t            cmd,
	input  logic [DAY_W-1:0]    first_day,
	input  logic [MONTH_W-1:0]  first_month,
	input  logic [YEAR_W-1:0]   first_year,
	input  logic [DAY_W-1:0]    second_day,
	input  logic [MONTH_W-1:0]  second_month,
	input  logic [YEAR_W-1:0]   second_year,
	input  logic                include_end,
	output logic [COUNT_W-1:0]  day_count,
	output logic [STATUS_W-1:0] status
);

	localparam int PROD_W = YEAR_W + RECIP_W;

	logic [DAY_W-1:0]    d1_q, d2_q;
	logic [MONTH_W-1:0]  m1_q, m2_q;
	logic [YEAR_W-1:0]   y1_q, y2_q;
	logic                inc_q;
	logic [CENT_W-1:0]   q1_q, q2_q;
	logic                leap1_q, leap2_q;
	logic [LEAPS_W-1:0]  lb1_q, lb2_q;
	logic [DOY_W-1:0]    a_q, b_q;
	logic [STATUS_W-1:0] stat_q;
	logic [SPAN_W-1:0]   span_q;
	logic [COUNT_W-1:0]  day_count_q;
	logic [STATUS_W-1:0] status_q;

	logic [YEAR_W-1:0]   div_x;
	logic [PROD_W-1:0]   div_prod;
	logic [CENT_W-1:0]   div_q;
	logic                m1_ok, m2_ok, d1_ok, d2_ok;
	logic [STATUS_W-1:0] stat_d;
	logic [YEAR_W-1:0]   dy;
	logic                order_bad;
	logic [SUM_W-1:0]    total;
	logic [COUNT_W-1:0]  count_sat;

	// shared divide by 100
	assign div_x    = cmd.div_second ? y2_q : y1_q;
	assign div_prod = PROD_W'(div_x) * PROD_W'(DIV100_MUL);
	assign div_q    = div_prod[DIV100_SHIFT +: CENT_W];

	assign m1_ok = (m1_q >= MONTH_FIRST) && (m1_q <= MONTH_LAST);
	assign m2_ok = (m2_q >= MONTH_FIRST) && (m2_q <= MONTH_LAST);
	assign d1_ok = (d1_q != '0) && (d1_q <= month_len(m1_q, leap1_q));
	assign d2_ok = (d2_q != '0) && (d2_q <= month_len(m2_q, leap2_q));

	always_comb begin
		priority if (!m1_ok || !m2_ok) begin
			stat_d = ST_MONTH;
		end else if (!d1_ok || !d2_ok) begin
			stat_d = ST_DAY;
		end else begin
			stat_d = ST_OK;
		end
	end

	assign dy        = y2_q - y1_q;
	assign order_bad = (y2_q < y1_q) || ((y2_q == y1_q) && (b_q < a_q));

	// true total never exceeds 2^23, so wrap-around arithmetic is safe
	assign total = SUM_W'(span_q) + SUM_W'(lb2_q) - SUM_W'(lb1_q)
		+ SUM_W'(b_q) + SUM_W'(inc_q) - SUM_W'(a_q);
	assign count_sat = (total > SUM_W'(COUNT_MAX)) ? COUNT_MAX : total[COUNT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			d1_q  <= first_day;
			m1_q  <= first_month;
			y1_q  <= first_year;
			d2_q  <= second_day;
			m2_q  <= second_month;
			y2_q  <= second_year;
			inc_q <= include_end;
		end
		if (cmd.div_first) begin
			q1_q <= div_q;
		end
		if (cmd.div_second) begin
			q2_q <= div_q;
		end
		if (cmd.leap_en) begin
			leap1_q <= is_leap(y1_q, q1_q);
			leap2_q <= is_leap(y2_q, q2_q);
			lb1_q   <= leaps_below(y1_q, q1_q);
			lb2_q   <= leaps_below(y2_q, q2_q);
		end
		if (cmd.check_en) begin
			stat_q <= stat_d;
			a_q    <= days_before(m1_q) + DOY_W'(d1_q) - DOY_W'(1)
				+ DOY_W'((m1_q > MONTH_FEB) && leap1_q);
			b_q    <= days_before(m2_q) + DOY_W'(d2_q) - DOY_W'(1)
				+ DOY_W'((m2_q > MONTH_FEB) && leap2_q);
		end
		if (cmd.span_en) begin
			span_q <= SPAN_W'(dy) * SPAN_W'(DAYS_PER_YEAR);
			if ((stat_q == ST_OK) && order_bad) begin
				stat_q <= ST_ORDER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_count_q <= '0;
			status_q    <= ST_OK;
		end else if (cmd.load_out) begin
			status_q    <= stat_q;
			day_count_q <= (stat_q == ST_OK) ? count_sat : '0;
		end
	end

	assign day_count = day_count_q;
	assign status    = status_q;

	`GDD_ASSERT_NOW(a_fail_zero, status_q != ST_OK, day_count_q == '0,
		"non-zero count reported with a failing status")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Day difference core testbench
// Drives date pairs through the request channel and checks every response
// word against a calendar predictor kept in this file. Directed tests cover
// field extremes, status priority and leap rules. Random spans follow, with
// idling on both channels, and then a closing stretch with no idling.
// ----------------------------------------------------------------------------
module testbench;
	import gdd_pkg::*;

	localparam int unsigned YEAR_TOP  = (1 << YEAR_W) - 1;
	localparam int unsigned CYCLE_CAP = 400000;

	// one request word as the sender sees it
	typedef struct {
		logic [DAY_W-1:0]   first_day;
		logic [MONTH_W-1:0] first_month;
		logic [YEAR_W-1:0]  first_year;
		logic [DAY_W-1:0]   second_day;
		logic [MONTH_W-1:0] second_month;
		logic [YEAR_W-1:0]  second_year;
		logic               include_end;
	} date_query_t;

	// one predicted response word
	typedef struct {
		logic [COUNT_W-1:0]  count;
		logic [STATUS_W-1:0] st;
	} span_result_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic [DAY_W-1:0]    first_day;
	logic [MONTH_W-1:0]  first_month;
	logic [YEAR_W-1:0]   first_year;
	logic [DAY_W-1:0]    second_day;
	logic [MONTH_W-1:0]  second_month;
	logic [YEAR_W-1:0]   second_year;
	logic                include_end;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [COUNT_W-1:0]  day_count;
	logic [STATUS_W-1:0] status;

	span_result_t pending_spans[$];
	int unsigned  mismatches = 0;
	int unsigned  cycle_count = 0;
	bit           idling_on;

	gregorian_day_difference_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.first_day    (first_day),
		.first_month  (first_month),
		.first_year   (first_year),
		.second_day   (second_day),
		.second_month (second_month),
		.second_year  (second_year),
		.include_end  (include_end),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.day_count    (day_count),
		.status       (status)
	);

	// ------------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------------

	function automatic bit leap_year(input int unsigned y);
		if (y % 100 == 0)
			return (y % 400) == 0;
		return (y % 4) == 0;
	endfunction

	// leap years strictly below y, year 0 included
	function automatic int unsigned leaps_under(input int unsigned y);
		return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
	endfunction

	// length of month m (1..12) in year y
	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		int unsigned len;
		case (m)
			2:             len = leap_year(y) ? 29 : 28;
			4, 6, 9, 11:   len = 30;
			default:       len = 31;
		endcase
		return len;
	endfunction

	// zero-based day of the year: sum the months gone by
	function automatic int unsigned day_in_year(input int unsigned d, input int unsigned m,
		input int unsigned y);
		int unsigned acc;
		acc = d - 1;
		for (int unsigned k = 1; k < m; k++)
			acc += month_days(k, y);
		return acc;
	endfunction

	function automatic bit month_bad(input int unsigned m);
		return m < 1 || m > 12;
	endfunction

	function automatic bit day_bad(input int unsigned d, input int unsigned m,
		input int unsigned y);
		return d < 1 || d > month_days(m, y);
	endfunction

	function automatic span_result_t predict_span(input date_query_t q);
		span_result_t r;
		int unsigned  doy_a;
		int unsigned  doy_b;
		int unsigned  total;
		r.count = '0;
		r.st    = ST_OK;
		// month checks first, then days, then order
		if (month_bad(q.first_month) || month_bad(q.second_month)) begin
			r.st = ST_MONTH;
		end else if (day_bad(q.first_day, q.first_month, q.first_year) ||
			day_bad(q.second_day, q.second_month, q.second_year)) begin
			r.st = ST_DAY;
		end else begin
			doy_a = day_in_year(q.first_day, q.first_month, q.first_year);
			doy_b = day_in_year(q.second_day, q.second_month, q.second_year);
			if (q.second_year < q.first_year ||
				(q.second_year == q.first_year && doy_b < doy_a)) begin
				r.st = ST_ORDER;
			end else begin
				total = doy_b + 365 * (q.second_year - q.first_year) +
					leaps_under(q.second_year) - leaps_under(q.first_year) - doy_a +
					q.include_end;
				// clip to the width of the count port
				r.count = (total > COUNT_MAX) ? COUNT_MAX : COUNT_W'(total);
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic date_query_t make_query(input int unsigned d1, input int unsigned m1,
		input int unsigned y1, input int unsigned d2, input int unsigned m2,
		input int unsigned y2, input int unsigned inc);
		date_query_t q;
		q.first_day    = DAY_W'(d1);
		q.first_month  = MONTH_W'(m1);
		q.first_year   = YEAR_W'(y1);
		q.second_day   = DAY_W'(d2);
		q.second_month = MONTH_W'(m2);
		q.second_year  = YEAR_W'(y2);
		q.include_end  = inc[0];
		return q;
	endfunction

	// ordering key: year, then month, then day
	function automatic int unsigned date_key(input int unsigned d, input int unsigned m,
		input int unsigned y);
		return (y << 9) | (m << 5) | d;
	endfunction

	// spread years over the full field, the four-digit range, century edges
	// and the leap-rule neighbourhood around 1900 and 2000
	function automatic int unsigned pick_year();
		int y;
		case ($urandom_range(0, 3))
			0:       y = $urandom_range(0, YEAR_TOP);
			1:       y = $urandom_range(0, 9999);
			2:       y = int'($urandom_range(0, 163)) * 100 + int'($urandom_range(0, 4)) - 2;
			default: y = $urandom_range(1895, 2105);
		endcase
		if (y < 0)
			y = 0;
		return y;
	endfunction

	function automatic void random_date(input int unsigned y, output int unsigned d,
		output int unsigned m);
		m = $urandom_range(1, 12);
		d = $urandom_range(1, month_days(m, y));
	endfunction

	// mostly well-formed ordered pairs; the rest reversed, damaged or raw noise
	function automatic date_query_t random_query();
		date_query_t q;
		int unsigned sel;
		int unsigned y1, y2, d1, m1, d2, m2, tmp;
		sel = $urandom_range(0, 99);
		y1  = pick_year();
		y2  = ($urandom_range(0, 2) == 0) ? pick_year() : y1 + $urandom_range(0, 2);
		if (y2 > YEAR_TOP)
			y2 = YEAR_TOP;
		random_date(y1, d1, m1);
		random_date(y2, d2, m2);
		if ((sel < 70 && date_key(d2, m2, y2) < date_key(d1, m1, y1)) ||
			(sel >= 70 && sel < 80 && date_key(d2, m2, y2) > date_key(d1, m1, y1))) begin
			tmp = d1; d1 = d2; d2 = tmp;
			tmp = m1; m1 = m2; m2 = tmp;
			tmp = y1; y1 = y2; y2 = tmp;
		end
		if (sel >= 80 && sel < 90) begin
			tmp = $urandom_range(12, 15);
			case ($urandom_range(0, 3))
				0:       d1 = month_days(m1, y1) + 1;
				1:       d2 = 0;
				2:       m1 = (tmp == 12) ? 0 : tmp;
				default: m2 = (tmp == 12) ? 0 : tmp;
			endcase
		end
		q = make_query(d1, m1, y1, d2, m2, y2, $urandom_range(0, 1));
		if (sel >= 90) begin
			q.first_day    = DAY_W'($urandom);
			q.first_month  = MONTH_W'($urandom);
			q.first_year   = YEAR_W'($urandom);
			q.second_day   = DAY_W'($urandom);
			q.second_month = MONTH_W'($urandom);
			q.second_year  = YEAR_W'($urandom);
		end
		return q;
	endfunction

	task automatic report_error(input string msg);
		mismatches++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// present one word, hold it until taken, then log its prediction
	task automatic send_query(input date_query_t q);
		int unsigned gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		first_day    <= q.first_day;
		first_month  <= q.first_month;
		first_year   <= q.first_year;
		second_day   <= q.second_day;
		second_month <= q.second_month;
		second_year  <= q.second_year;
		include_end  <= q.include_end;
		req_valid    <= 1'b1;
		do @(posedge clk); while (req_stall);
		pending_spans.push_back(predict_span(q));
	endtask

	// drop valid and hold off until every response word is back
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_spans.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	task automatic test_field_extremes();
		send_query(make_query(0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(31, 15, YEAR_TOP, 31, 15, YEAR_TOP, 1));
		// widest four-digit span
		send_query(make_query(1, 1, 0, 31, 12, 9999, 1));
		// widest span the fields allow: clips at the count ceiling
		send_query(make_query(1, 1, 0, 31, 12, YEAR_TOP, 1));
		send_query(make_query(1, 1, 5000, 31, 12, YEAR_TOP, 0));
		// equal dates, with and without the end day
		send_query(make_query(15, 6, 2024, 15, 6, 2024, 0));
		send_query(make_query(15, 6, 2024, 15, 6, 2024, 1));
		send_query(make_query(31, 12, YEAR_TOP, 31, 12, YEAR_TOP, 1));
	endtask

	task automatic test_check_priority();
		// bad month wins over bad day, on either date
		send_query(make_query(0, 0, 2000, 10, 5, 2001, 0));
		send_query(make_query(0, 3, 2000, 10, 13, 2001, 1));
		// bad first day, then bad second day even with dates reversed
		send_query(make_query(0, 4, 2000, 31, 4, 2001, 0));
		send_query(make_query(10, 5, 2005, 31, 4, 2001, 1));
		// reversed order is flagged even with the end day counted
		send_query(make_query(1, 1, 2001, 31, 12, 2000, 1));
		send_query(make_query(2, 7, 1999, 1, 7, 1999, 0));
	endtask

	task automatic test_leap_rules();
		send_query(make_query(29, 2, 2000, 1, 3, 2000, 0));
		send_query(make_query(29, 2, 1900, 1, 3, 1900, 0));
		send_query(make_query(29, 2, 2004, 28, 2, 2005, 1));
		send_query(make_query(1, 1, 2001, 29, 2, 2001, 0));
		// year zero divides by 400
		send_query(make_query(29, 2, 0, 1, 3, 0, 0));
		send_query(make_query(28, 2, 1900, 1, 3, 1900, 0));
		send_query(make_query(1, 1, 1899, 1, 1, 1901, 0));
		send_query(make_query(1, 1, 1999, 1, 1, 2001, 0));
		send_query(make_query(1, 3, 2099, 1, 3, 2101, 1));
		send_query(make_query(30, 2, 2000, 1, 3, 2000, 0));
	endtask

	// short bursts, each drained before the next one starts
	task automatic test_drained_bursts();
		for (int b = 0; b < 5; b++) begin
			for (int i = 0; i < 8; i++)
				send_query(random_query());
			wait_drained();
		end
	endtask

	task automatic test_random_spans(input int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			send_query(random_query());
			if (i % 300 == 299)
				wait_drained();
		end
	endtask

	// closing stretch at full rate: no gaps, no stalls
	task automatic test_back_to_back(input int unsigned n);
		idling_on = 1'b0;
		for (int unsigned i = 0; i < n; i++)
			send_query(random_query());
	endtask

	// ------------------------------------------------------------------------
	// Clock, reset and run order
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		first_day    = '0;
		first_month  = '0;
		first_year   = '0;
		second_day   = '0;
		second_month = '0;
		second_year  = '0;
		include_end  = 1'b0;
		idling_on    = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_check_priority();
		test_leap_rules();
		test_drained_bursts();
		test_random_spans(1450);
		test_back_to_back(100);

		@(negedge clk);
		req_valid <= 1'b0;
		// the watchdog bounds this wait
		while (pending_spans.size() != 0)
			@(posedge clk);
		// allow for a stray word past the last expected response
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("gregorian_day_difference_core test passed");
		else
			$display("gregorian_day_difference_core test failed");
		$finish;
	end

	// Response stall: random bursts, none once idling is off
	initial begin
		int unsigned burst;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 12);
				rsp_stall <= 1'b1;
				repeat (burst - 1) @(negedge clk);
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Check each response word taken against the oldest prediction
	always @(posedge clk) begin
		span_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_spans.size() == 0) begin
				report_error($sformatf("response word with none pending: count %0d status %0d",
					day_count, status));
			end else begin
				want = pending_spans.pop_front();
				if (day_count !== want.count)
					report_error($sformatf("day_count %0d, predicted %0d",
						day_count, want.count));
				if (status !== want.st)
					report_error($sformatf("status %0d, predicted %0d", status, want.st));
			end
		end
	end

	// Watchdog: stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_CAP) begin
			$display("gregorian_day_difference_core test failed");
			$finish;
		end
	end

endmodule
